### design/acrms_pkg.sv
// Shared types and constants for the AC current RMS meter.
// Used by acrms_ctrl, acrms_dp and ac_current_rms_meter; depends on nothing.
package acrms_pkg;

    // Configuration register map (word index of the byte address).
    localparam int REG_IDX_W = 3;
    localparam int ADDR_W    = 5;
    localparam logic [REG_IDX_W-1:0] REG_CALIB   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MEASURE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WEIGHT  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_NOISE   = 3'd4;

    // Fixed field widths.
    localparam int CFG_W    = 16;
    localparam int WEIGHT_W = 9;
    localparam int IRMS_W   = 17;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;
    localparam logic [IRMS_W-1:0]   IRMS_MAX   = 17'h1FFFF;

    // End-of-window arithmetic: 64-bit mean, 32-bit root.
    localparam int MEAN_W     = 64;
    localparam int ROOT_W     = 32;
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;
    localparam int ITER_W     = 6;
    localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(DIV_STEPS - 1);
    localparam logic [ITER_W-1:0] SQRT_LAST = ITER_W'(SQRT_STEPS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILT,
        S_SQ,
        S_ACC,
        S_DINIT,
        S_DIV,
        S_SQRT,
        S_MUL,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic filt;
        logic square;
        logic accum;
        logic div_init;
        logic div_step;
        logic sqrt_step;
        logic scale;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic phase_measure;
        logic last;
        logic out_busy;
    } t_stat;

endpackage

### design/acrms_ctrl.sv
// Sequencer of the AC current RMS meter: per-sample steps and end-of-window steps.
// Depends on acrms_pkg for the state type and the command/status structs.
module acrms_ctrl
    import acrms_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_sample_valid,
    output logic  o_sample_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state              r_state, n_state;
    logic [ITER_W-1:0]   r_cnt, n_cnt;
    logic                accept;

    assign accept = i_sample_valid && o_sample_ready;

    // State and iteration counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (accept && i_stat.phase_measure) n_state = S_FILT;
            end
            S_FILT:  n_state = S_SQ;
            S_SQ:    n_state = S_ACC;
            S_ACC:   n_state = i_stat.last ? S_DINIT : S_IDLE;
            S_DINIT: begin
                n_state = S_DIV;
                n_cnt   = '0;
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_SQRT;
                    n_cnt   = '0;
                end
            end
            S_SQRT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == SQRT_LAST) begin
                    n_state = S_MUL;
                    n_cnt   = '0;
                end
            end
            S_MUL:   n_state = S_OUT;
            S_OUT: begin
                if (!i_stat.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd          = '0;
        o_sample_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_sample_ready = 1'b1;
                o_cmd.take     = accept;
            end
            S_FILT:  o_cmd.filt      = 1'b1;
            S_SQ:    o_cmd.square    = 1'b1;
            S_ACC:   o_cmd.accum     = 1'b1;
            S_DINIT: o_cmd.div_init  = 1'b1;
            S_DIV:   o_cmd.div_step  = 1'b1;
            S_SQRT:  o_cmd.sqrt_step = 1'b1;
            S_MUL:   o_cmd.scale     = 1'b1;
            S_OUT:   o_cmd.finish    = !i_stat.out_busy;
            default: o_cmd = '0;
        endcase
    end

    // The divider runs exactly its step count before the root starts.
    a_div_to_sqrt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == DIV_LAST) |=> (r_state == S_SQRT))
        else $error("divider did not hand over to the square root");

    // At most one datapath command is active in a cycle.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command active");

    // A measurement sample always runs through the filter next.
    a_take_filt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take && i_stat.phase_measure) |=> (r_state == S_FILT))
        else $error("measurement sample skipped the filter");

endmodule

### design/acrms_dp.sv
// Datapath of the AC current RMS meter: min/max, filter, square sum, divider,
// square root, scaling and the result register. Depends on acrms_pkg.
module acrms_dp
    import acrms_pkg::*;
#(
    parameter int SAMPLE_BITS = 10,
    parameter int COUNT_BITS  = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  t_cmd                   i_cmd,
    input  logic [COUNT_BITS-1:0]  i_calib_count,
    input  logic [COUNT_BITS-1:0]  i_measure_count,
    input  logic [WEIGHT_W-1:0]    i_weight_new,
    input  logic [CFG_W-1:0]       i_gain_q8,
    input  logic [CFG_W-1:0]       i_noise_ma,
    output t_stat                  o_stat,
    output logic                   o_result_valid,
    input  logic                   i_result_ready,
    output logic [IRMS_W-1:0]      o_irms_ma,
    output logic [SAMPLE_BITS:0]   o_midpoint_sum
);

    localparam int S      = SAMPLE_BITS;
    localparam int C_W    = S + 3;
    localparam int DIFF_W = S + 11;
    localparam int FILT_W = S + 10;
    localparam int ACC_W  = S + 21;
    localparam int SQ_W   = 2 * FILT_W - 1;
    localparam int SUM_RAW = SQ_W + COUNT_BITS;
    localparam int SUM_W  = (SUM_RAW > MEAN_W) ? SUM_RAW : MEAN_W + 1;
    localparam int N_W    = COUNT_BITS + 1;
    localparam int REM_W  = N_W + 1;
    localparam int SREM_W = ROOT_W + 2;
    localparam int STRY_W = ROOT_W + 3;
    localparam int MA_W   = ROOT_W + CFG_W;

    logic                        r_phase;
    logic [COUNT_BITS-1:0]       r_count;
    logic [S:0]                  r_min;
    logic [S-1:0]                r_max;
    logic signed [FILT_W-1:0]    r_filt;
    logic [SUM_W-1:0]            r_sum;
    logic                        r_last;
    logic [N_W-1:0]              r_n;
    logic signed [DIFF_W-1:0]    r_diff;
    logic [SQ_W-1:0]             r_sq;
    logic [MEAN_W-1:0]           r_dvd;
    logic [N_W-1:0]              r_rem;
    logic [SREM_W-1:0]           r_srem;
    logic [ROOT_W-1:0]           r_root;
    logic [MA_W-1:0]             r_ma;
    logic                        r_out_valid;
    logic [IRMS_W-1:0]           r_irms;
    logic [S:0]                  r_mid;

    logic [S:0]                  mid;
    logic [N_W-1:0]              next_cnt;
    logic [N_W-1:0]              calib_lim, meas_lim;
    logic signed [C_W-1:0]       centred;
    logic signed [DIFF_W-1:0]    diff;
    logic [WEIGHT_W-1:0]         w_clamp;
    logic signed [ACC_W-1:0]     acc;
    logic signed [2*FILT_W-1:0]  sq_full;
    logic [REM_W-1:0]            rem_sh;
    logic [REM_W-1:0]            rem_sub;
    logic [STRY_W-1:0]           srem_sh, strial;
    logic [MA_W-CFG_W-1:0]       ma_top;
    logic [IRMS_W-1:0]           irms;

    assign o_stat.phase_measure = r_phase;
    assign o_stat.last          = r_last;
    assign o_stat.out_busy      = r_out_valid && !i_result_ready;
    assign o_result_valid       = r_out_valid;
    assign o_irms_ma            = r_irms;
    assign o_midpoint_sum       = r_mid;

    // Sample count and phase limits; a zero count acts as one.
    assign mid       = r_min + {1'b0, r_max};
    assign next_cnt  = {1'b0, r_count} + 1'b1;
    assign calib_lim = (i_calib_count == '0) ? N_W'(1) : {1'b0, i_calib_count};
    assign meas_lim  = (i_measure_count == '0) ? N_W'(1) : {1'b0, i_measure_count};

    // Centred sample in half counts, Q8, minus the filter state.
    assign centred = $signed({2'b00, i_sample, 1'b0}) - $signed({2'b00, mid});
    assign diff    = $signed({centred, 8'd0}) - DIFF_W'(r_filt);

    // Filter: f + w*(c - f), rounded half up.
    assign w_clamp = (i_weight_new > WEIGHT_ONE) ? WEIGHT_ONE : i_weight_new;
    assign acc = $signed({1'b0, w_clamp}) * r_diff
               + $signed({(ACC_W-8)'(r_filt), 8'd0})
               + ACC_W'(128);
    assign sq_full = r_filt * r_filt;

    // One restoring divider step.
    assign rem_sh  = {r_rem, r_dvd[MEAN_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_n};

    // One square root step on two bits of the mean; the remainder's top bit
    // is always clear.
    assign srem_sh = {r_srem[SREM_W-2:0], r_dvd[MEAN_W-1 -: 2]};
    assign strial  = {1'b0, r_root, 2'b01};

    // Scaling, noise floor and saturation.
    assign ma_top = r_ma[MA_W-1:CFG_W];
    always_comb begin
        if (ma_top <= {{(MA_W-2*CFG_W){1'b0}}, i_noise_ma}) begin
            irms = '0;
        end else if (ma_top > {{(MA_W-CFG_W-IRMS_W){1'b0}}, IRMS_MAX}) begin
            irms = IRMS_MAX;
        end else begin
            irms = ma_top[IRMS_W-1:0];
        end
    end

    // Window state: phase, counter, min/max, filter and sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            r_phase <= 1'b0;
            r_count <= '0;
            r_min   <= {1'b1, {S{1'b0}}};
            r_max   <= '0;
            r_filt  <= '0;
            r_sum   <= '0;
            r_last  <= 1'b0;
        end else begin
            if (i_cmd.take && !r_phase) begin
                if (i_sample > r_max) r_max <= i_sample;
                if ({1'b0, i_sample} < r_min) r_min <= {1'b0, i_sample};
                if (next_cnt >= calib_lim) begin
                    r_phase <= 1'b1;
                    r_count <= '0;
                end else begin
                    r_count <= next_cnt[COUNT_BITS-1:0];
                end
            end
            if (i_cmd.take && r_phase) begin
                r_count <= next_cnt[COUNT_BITS-1:0];
                r_last  <= (next_cnt >= meas_lim);
            end
            if (i_cmd.filt) r_filt <= acc[FILT_W+7:8];
            if (i_cmd.accum) r_sum <= r_sum + SUM_W'(r_sq);
        end
    end

    // Working registers of the per-sample and end-of-window arithmetic.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && r_phase) begin
            r_diff <= diff;
            r_n    <= next_cnt;
        end
        if (i_cmd.square) r_sq <= sq_full[SQ_W-1:0];
        if (i_cmd.div_init) begin
            r_dvd  <= (|r_sum[SUM_W-1:MEAN_W]) ? '1 : r_sum[MEAN_W-1:0];
            r_rem  <= '0;
            r_srem <= '0;
            r_root <= '0;
        end
        if (i_cmd.div_step) begin
            if (!rem_sub[REM_W-1]) begin
                r_rem <= rem_sub[N_W-1:0];
                r_dvd <= {r_dvd[MEAN_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[N_W-1:0];
                r_dvd <= {r_dvd[MEAN_W-2:0], 1'b0};
            end
        end
        if (i_cmd.sqrt_step) begin
            r_dvd <= {r_dvd[MEAN_W-3:0], 2'b00};
            if (srem_sh >= strial) begin
                r_srem <= SREM_W'(srem_sh - strial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_srem <= srem_sh[SREM_W-1:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.scale) r_ma <= r_root * i_gain_q8;
        if (i_cmd.finish) begin
            r_irms <= irms;
            r_mid  <= mid;
        end
    end

    // Result request handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_result_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // The divider remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |=> (r_rem < r_n))
        else $error("divider remainder not below divisor");

    // A finished window restarts in the calibration phase with a valid result.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (!r_phase && r_out_valid && r_sum == '0))
        else $error("window did not restart after a result");

endmodule

### design/ac_current_rms_meter.sv
// Top level of the AC current RMS meter: configuration registers and the
// controller/datapath pair. Depends on acrms_pkg, acrms_ctrl and acrms_dp.
//
// The meter takes one ADC sample per request. A calibration-phase sample is
// taken directly on acceptance. A measurement-phase sample runs through
// capture, filter multiply, square and accumulate before the next one is
// accepted. The last sample of a window adds the bit-serial divider, the
// digit-by-digit square root and scaling. A finished result waits in its own
// register, so the next window's samples are accepted while it is still
// pending.
module ac_current_rms_meter
    import acrms_pkg::*;
#(
    parameter int SAMPLE_BITS = 10,
    parameter int COUNT_BITS  = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_sample_valid,
    output logic                   o_sample_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_result_valid,
    input  logic                   i_result_ready,
    output logic [IRMS_W-1:0]      o_irms_ma,
    output logic [SAMPLE_BITS:0]   o_midpoint_sum,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [COUNT_BITS-1:0] r_calib_count;
    logic [COUNT_BITS-1:0] r_measure_count;
    logic [WEIGHT_W-1:0]   r_weight_new;
    logic [CFG_W-1:0]      r_gain_q8;
    logic [CFG_W-1:0]      r_noise_ma;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  wr_en;
    t_cmd                  cmd;
    t_stat                 stat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib_count   <= COUNT_BITS'(285);
            r_measure_count <= COUNT_BITS'(312);
            r_weight_new    <= WEIGHT_W'(205);
            r_gain_q8       <= CFG_W'(9920);
            r_noise_ma      <= CFG_W'(80);
        end else if (wr_en) begin
            case (reg_idx)
                REG_CALIB:   r_calib_count   <= COUNT_BITS'(pwdata[CFG_W-1:0]);
                REG_MEASURE: r_measure_count <= COUNT_BITS'(pwdata[CFG_W-1:0]);
                REG_WEIGHT:  r_weight_new    <= pwdata[WEIGHT_W-1:0];
                REG_GAIN:    r_gain_q8       <= pwdata[CFG_W-1:0];
                REG_NOISE:   r_noise_ma      <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_idx)
            REG_CALIB:   prdata = 32'(r_calib_count);
            REG_MEASURE: prdata = 32'(r_measure_count);
            REG_WEIGHT:  prdata = 32'(r_weight_new);
            REG_GAIN:    prdata = 32'(r_gain_q8);
            REG_NOISE:   prdata = 32'(r_noise_ma);
            default:     prdata = '0;
        endcase
    end

    acrms_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_stat         (stat),
        .o_cmd          (cmd)
    );

    acrms_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_sample        (i_sample),
        .i_cmd           (cmd),
        .i_calib_count   (r_calib_count),
        .i_measure_count (r_measure_count),
        .i_weight_new    (r_weight_new),
        .i_gain_q8       (r_gain_q8),
        .i_noise_ma      (r_noise_ma),
        .o_stat          (stat),
        .o_result_valid  (o_result_valid),
        .i_result_ready  (i_result_ready),
        .o_irms_ma       (o_irms_ma),
        .o_midpoint_sum  (o_midpoint_sum)
    );

endmodule

### sim/testbench.sv
// Self-checking testbench for the AC current RMS meter: drives ADC samples,
// writes the APB registers between phases and checks each window result.
// Depends on acrms_pkg and ac_current_rms_meter.
`timescale 1ns / 100ps

module testbench;
    import acrms_pkg::*;

    localparam int SB = 10;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_sample_valid = 1'b0;
    logic              o_sample_ready;
    logic [SB-1:0]     i_sample = '0;
    logic              o_result_valid;
    logic              i_result_ready = 1'b0;
    logic [IRMS_W-1:0] o_irms_ma;
    logic [SB:0]       o_midpoint_sum;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    ac_current_rms_meter i_dut (.*);

    always #5 i_clk = ~i_clk;

    typedef struct packed {
        logic [IRMS_W-1:0] irms;
        logic [SB:0]       mid;
    } t_window;

    // Predictor copy of registers and window state.
    logic [15:0] calib_len, meas_len, gain, noise;
    logic [8:0]  weight;
    bit          in_measure;
    int unsigned sample_cnt;
    int unsigned lo_seen, hi_seen;
    longint      filt_q8;
    logic [63:0] sq_sum;

    logic [SB-1:0] sample_queue[$];
    t_window       window_queue[$];
    bit            failed = 1'b0;
    int            idle_pct = 36;
    int            hold_cycles = 0;

    // Acceptance flag as seen at the last rising edge.
    logic o_sample_ready_q = 1'b0;

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic restart_window();
        in_measure = 0;
        sample_cnt = 0;
        lo_seen = 1 << SB;
        hi_seen = 0;
        filt_q8 = 0;
        sq_sum = 0;
    endtask

    // Advance the predictor by one accepted sample.
    task automatic predict_sample(logic [SB-1:0] s);
        int unsigned nxt, lim;
        longint w, c, acc;
        logic [63:0] mag, sq, mean, ma;
        t_window r;
        nxt = sample_cnt + 1;
        if (!in_measure) begin
            lim = (calib_len == 0) ? 1 : calib_len;
            if (s > hi_seen) hi_seen = s;
            if (s < lo_seen) lo_seen = s;
            if (nxt >= lim) begin
                in_measure = 1;
                sample_cnt = 0;
            end else begin
                sample_cnt = nxt;
            end
        end else begin
            lim = (meas_len == 0) ? 1 : meas_len;
            w = (weight > 256) ? 256 : weight;
            c = 2 * longint'(s) - longint'(hi_seen + lo_seen);
            acc = w * c * 256 + (256 - w) * filt_q8 + 128;
            filt_q8 = acc >>> 8;
            mag = (filt_q8 < 0) ? -filt_q8 : filt_q8;
            sq = (mag > 64'hFFFF_FFFF) ? '1 : mag * mag;
            sq_sum = (sq_sum > ~sq) ? '1 : sq_sum + sq;
            if (nxt < lim) begin
                sample_cnt = nxt;
            end else begin
                mean = sq_sum / nxt;
                ma = (int_sqrt(mean) * gain) >> 16;
                if (ma <= noise) ma = 0;
                if (ma > IRMS_MAX) ma = IRMS_MAX;
                r.irms = ma[IRMS_W-1:0];
                r.mid = (SB+1)'(hi_seen + lo_seen);
                window_queue.push_back(r);
                restart_window();
            end
        end
    endtask

    // APB write: setup then access, changes at the falling edge.
    task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= ADDR_W'(idx) << 2; pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_CALIB:   calib_len = val[15:0];
            REG_MEASURE: meas_len = val[15:0];
            REG_WEIGHT:  weight = val[8:0];
            REG_GAIN:    gain = val[15:0];
            REG_NOISE:   noise = val[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (sample_queue.size() != 0 || i_sample_valid || window_queue.size() != 0)
            @(posedge i_clk);
        // Finishing window arithmetic may still be running.
        repeat (150) @(posedge i_clk);
    endtask

    task automatic set_config(int cl, int ml, int w, int g, int n);
        reg_write(REG_CALIB, cl);
        reg_write(REG_MEASURE, ml);
        reg_write(REG_WEIGHT, w);
        reg_write(REG_GAIN, g);
        reg_write(REG_NOISE, n);
    endtask

    // Sine-like window content with the given amplitude and offset plus small random noise.
    task automatic queue_wave(int count, int amp, int ofs);
        int v;
        for (int k = 0; k < count; k++) begin
            v = ofs + ((k % 4 == 0) ? amp : (k % 4 == 2) ? -amp : 0)
                + $urandom_range(0, 6) - 3;
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
            sample_queue.push_back(SB'(v));
        end
    endtask

    // Sample driver.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_sample_valid || o_sample_ready_q) begin
                if (sample_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    i_sample_valid <= 1;
                    i_sample <= sample_queue.pop_front();
                end else begin
                    i_sample_valid <= 0;
                end
            end
        end
    end

    // Result receiver: random idling, or a counted hold-off stretch.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_result_ready <= 0;
            end else begin
                i_result_ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    // Monitor: predicts on each accepted sample, checks each accepted result.
    always @(posedge i_clk) begin
        t_window exp_w;
        o_sample_ready_q <= i_sample_valid && o_sample_ready;
        if (i_rst_n) begin
            if (i_sample_valid && o_sample_ready) predict_sample(i_sample);
            if (o_result_valid && i_result_ready) begin
                if (window_queue.size() == 0) begin
                    $display("%0t: unexpected result irms=%0d mid=%0d", $time,
                             o_irms_ma, o_midpoint_sum);
                    failed = 1;
                end else begin
                    exp_w = window_queue.pop_front();
                    if (exp_w.irms !== o_irms_ma) begin
                        $display("%0t: irms_ma expected %0d actual %0d", $time,
                                 exp_w.irms, o_irms_ma);
                        failed = 1;
                    end
                    if (exp_w.mid !== o_midpoint_sum) begin
                        $display("%0t: midpoint_sum expected %0d actual %0d", $time,
                                 exp_w.mid, o_midpoint_sum);
                        failed = 1;
                    end
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int cl, ml;
        calib_len = 285; meas_len = 312; weight = 205; gain = 9920; noise = 80;
        restart_window();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: tiny windows, field extremes, zero lengths, weight above one.
        set_config(0, 0, 511, 65535, 0);
        sample_queue.push_back(0); sample_queue.push_back(1023);
        sample_queue.push_back(1023); sample_queue.push_back(0);
        sample_queue.push_back(10'h2AA); sample_queue.push_back(10'h155);
        wait_drained();
        set_config(2, 3, 256, 65535, 0);
        sample_queue.push_back(0); sample_queue.push_back(1023);
        sample_queue.push_back(1023); sample_queue.push_back(0);
        sample_queue.push_back(1023);
        sample_queue.push_back(0); sample_queue.push_back(1023);
        sample_queue.push_back(512); sample_queue.push_back(512);
        sample_queue.push_back(512);
        wait_drained();
        set_config(1, 2, 0, 0, 65535);
        sample_queue.push_back(1023); sample_queue.push_back(0); sample_queue.push_back(5);
        wait_drained();

        // Backpressure: receiver holds off while the sender keeps going.
        set_config(2, 2, 205, 9920, 80);
        hold_cycles = 400;
        queue_wave(60, 400, 512);
        wait_drained();

        // Random phases with varied settings; one stretch without idling.
        for (int ph = 0; ph < 4; ph++) begin
            cl = $urandom_range(1, 8);
            ml = $urandom_range(1, 12);
            idle_pct = (ph == 2) ? 0 : 36;
            set_config(cl, ml, $urandom_range(0, 300), $urandom_range(0, 65535),
                       (ph % 2 == 0) ? $urandom_range(0, 200) : $urandom_range(0, 65535));
            for (int win = 0; win < 2; win++)
                queue_wave(cl + ml, $urandom_range(0, 511), $urandom_range(0, 1023));
            // Noise samples that span every bit.
            for (int k = 0; k < 8; k++) sample_queue.push_back(SB'($urandom));
            wait_drained();
        end
        idle_pct = 36;
        set_config(285, 312, 205, 9920, 80);
        queue_wave(597, 300, 512);
        wait_drained();

        if (!failed) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
